@@ design/gstr_pkg.sv @@
// shared types, constants and codes for the gardner timing recovery block
`timescale 1ns / 1ps

package gstr_pkg;

  localparam int HIST_LEN    = 32;
  localparam int HIST_AW     = $clog2(HIST_LEN);
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_W      = 16;
  localparam int PHASE_W     = 24;
  localparam int PERIOD_W    = 20;
  localparam int GAIN_W      = 24;
  localparam int INTEG_W     = 32;
  localparam int CNT_W       = 16;
  localparam int ERR_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int MUL_A_W     = 24;
  localparam int MUL_B_W     = 32;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
  localparam int GAIN_SHIFT  = 37;
  localparam int K_W         = MUL_P_W - GAIN_SHIFT;
  localparam int OMEGA_SUM_W = INTEG_W + 2;

  localparam logic [PERIOD_W-1:0] PERIOD_MIN_RST     = PERIOD_W'(196608);
  localparam logic [PERIOD_W-1:0] PERIOD_MAX_RST     = PERIOD_W'(327680);
  localparam logic [PERIOD_W-1:0] PERIOD_NOMINAL_RST = PERIOD_W'(262144);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [GAIN_W-1:0]      gain_t;
  typedef logic [PERIOD_W-1:0]           period_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INTEG_GAIN     = 3'd1,
    REG_PERIOD_MIN     = 3'd2,
    REG_PERIOD_MAX     = 3'd3,
    REG_PERIOD_NOMINAL = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SYM_RD0,
    ST_SYM_RD1,
    ST_SYM_MUL,
    ST_SYM_RES,
    ST_MID_MUL,
    ST_MID_RES,
    ST_ERR_MUL,
    ST_K1_MUL,
    ST_K2_MUL,
    ST_INTEG,
    ST_OMEGA
  } state_e;

  typedef struct packed {
    gain_t   prop_gain;
    gain_t   integ_gain;
    period_t period_min;
    period_t period_max;
    logic    nominal_ld;
    period_t nominal_val;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [HIST_AW-1:0] waddr;
    sample_t            wdata;
    logic [HIST_AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic                       en;
    logic signed [MUL_A_W-1:0]  a;
    logic signed [MUL_B_W-1:0]  b;
  } mul_req_t;

endpackage

@@ design/gstr_if.sv @@
// handshake channel interfaces for samples, symbols and register writes
`timescale 1ns / 1ps

interface gstr_sample_if;
  import gstr_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface gstr_symbol_if;
  import gstr_pkg::*;
  logic             valid;
  logic             ready;
  sample_t          symbol_out;
  logic [CNT_W-1:0] symbol_number;
  modport source (output valid, output symbol_out, output symbol_number, input ready);
  modport sink (input valid, input symbol_out, input symbol_number, output ready);
endinterface

interface gstr_cfg_if;
  import gstr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/gstr_hist_mem.sv @@
// sample history memory with per-entry valid bits, registered read
`timescale 1ns / 1ps

module gstr_hist_mem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gstr_pkg::mem_req_t req_i,
  output gstr_pkg::sample_t  rdata_o
);
  import gstr_pkg::*;

  sample_t             mem [HIST_LEN];
  logic [HIST_LEN-1:0] valid_q;
  sample_t             rdata_q;
  logic                rvalid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      rvalid_q <= valid_q[req_i.raddr];
    end
  end

  // never-written entries read as zero
  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

@@ design/gstr_mul.sv @@
// shared signed multiplier with registered product
`timescale 1ns / 1ps

module gstr_mul (
  input  logic                                clk_i,
  input  gstr_pkg::mul_req_t                  req_i,
  output logic signed [gstr_pkg::MUL_P_W-1:0] prod_o
);
  import gstr_pkg::*;

  logic signed [MUL_P_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= MUL_P_W'(req_i.a) * MUL_P_W'(req_i.b);
    end
  end

  assign prod_o = prod_q;

endmodule

@@ design/gstr_regs.sv @@
// configuration registers: loop gains, period limits and the nominal period load
`timescale 1ns / 1ps

module gstr_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_valid_i,
  output logic                            wr_ready_o,
  input  logic [gstr_pkg::CFG_IDX_W-1:0]  wr_index_i,
  input  logic [gstr_pkg::CFG_DATA_W-1:0] wr_data_i,
  output gstr_pkg::cfg_t                  cfg_o
);
  import gstr_pkg::*;

  gain_t   prop_gain_q, integ_gain_q;
  period_t period_min_q, period_max_q;
  logic    nominal_ld;

  assign wr_ready_o = 1'b1;
  assign nominal_ld = wr_valid_i && (wr_index_i == REG_PERIOD_NOMINAL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= '0;
      integ_gain_q <= '0;
      period_min_q <= PERIOD_MIN_RST;
      period_max_q <= PERIOD_MAX_RST;
    end else if (wr_valid_i) begin
      case (wr_index_i)
        REG_PROP_GAIN:  prop_gain_q  <= wr_data_i[GAIN_W-1:0];
        REG_INTEG_GAIN: integ_gain_q <= wr_data_i[GAIN_W-1:0];
        REG_PERIOD_MIN: period_min_q <= wr_data_i[PERIOD_W-1:0];
        REG_PERIOD_MAX: period_max_q <= wr_data_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.prop_gain   = prop_gain_q;
    cfg_o.integ_gain  = integ_gain_q;
    cfg_o.period_min  = period_min_q;
    cfg_o.period_max  = period_max_q;
    cfg_o.nominal_ld  = nominal_ld;
    cfg_o.nominal_val = wr_data_i[PERIOD_W-1:0];
  end

endmodule

@@ design/gstr_ctrl.sv @@
// sequencer and loop state: phase, interpolation, gardner error, pi loop
`timescale 1ns / 1ps

module gstr_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  gstr_pkg::sample_t                   sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output gstr_pkg::sample_t                   symbol_o,
  output logic [gstr_pkg::CNT_W-1:0]          number_o,
  input  gstr_pkg::cfg_t                      cfg_i,
  output gstr_pkg::mem_req_t                  mem_req_o,
  input  gstr_pkg::sample_t                   mem_rdata_i,
  output gstr_pkg::mul_req_t                  mul_req_o,
  input  logic signed [gstr_pkg::MUL_P_W-1:0] prod_i
);
  import gstr_pkg::*;

  state_e                     state_q, state_d;
  logic [HIST_AW-1:0]         wp_q, wp_d;
  logic [PHASE_W-1:0]         mu_q, mu_d, omega_q, omega_d;
  logic signed [INTEG_W-1:0]  integ_q, integ_d;
  sample_t                    prev_q, prev_d;
  sample_t                    x0_q, x0_d, sym_q, sym_d, mid_q, mid_d;
  logic signed [ERR_W-1:0]    e_q, e_d;
  logic signed [K_W-1:0]      k1_q, k1_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       out_valid_q, out_valid_d;
  sample_t                    out_sym_q, out_sym_d;
  logic [CNT_W-1:0]           out_num_q, out_num_d;

  logic                       accept, strobe, emit;
  logic [PHASE_W-1:0]         mu_inc, frac_mid;
  logic [PHASE_W:0]           mu_diff;
  logic [HIST_AW-1:0]         idx_s0, idx_s1, idx_m0, idx_m1;
  logic signed [SAMPLE_BITS:0] rd_diff, err_diff;
  logic signed [MUL_P_W-1:0]  interp_rnd, gain_rnd;
  sample_t                    interp_val;
  logic signed [K_W-1:0]      k_val;
  logic signed [INTEG_W:0]    integ_sum;
  logic signed [OMEGA_SUM_W-1:0] om_sum, om_hi, om_lim;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign symbol_o    = out_sym_q;
  assign number_o    = out_num_q;

  // phase step and strobe test
  assign mu_inc   = mu_q + PHASE_W'(1 << FRAC_W);
  assign mu_diff  = {1'b0, mu_inc} - {1'b0, omega_q};
  assign strobe   = !mu_diff[PHASE_W];
  assign frac_mid = mu_q + {1'b0, omega_q[PHASE_W-1:1]};

  // history addresses, counted back from the newest sample
  assign idx_s0 = wp_q - HIST_AW'(1) - mu_q[FRAC_W +: HIST_AW];
  assign idx_s1 = idx_s0 - HIST_AW'(1);
  assign idx_m0 = wp_q - HIST_AW'(1) - frac_mid[FRAC_W +: HIST_AW];
  assign idx_m1 = idx_m0 - HIST_AW'(1);

  assign rd_diff    = {mem_rdata_i[SAMPLE_BITS-1], mem_rdata_i} - {x0_q[SAMPLE_BITS-1], x0_q};
  assign err_diff   = {sym_q[SAMPLE_BITS-1], sym_q} - {prev_q[SAMPLE_BITS-1], prev_q};
  assign interp_rnd = prod_i + MUL_P_W'(1 << (FRAC_W - 1));
  assign interp_val = x0_q + interp_rnd[FRAC_W +: SAMPLE_BITS];
  assign gain_rnd   = prod_i + (MUL_P_W'(1) << (GAIN_SHIFT - 1));
  assign k_val      = gain_rnd[GAIN_SHIFT +: K_W];
  assign integ_sum  = {integ_q[INTEG_W-1], integ_q}
                    + {{(INTEG_W + 1 - K_W){k_val[K_W-1]}}, k_val};

  // new period: sum, then upper limit, then lower limit
  assign om_sum = {{(OMEGA_SUM_W - PHASE_W){1'b0}}, omega_q}
                + {{(OMEGA_SUM_W - K_W){k1_q[K_W-1]}}, k1_q}
                + {{(OMEGA_SUM_W - INTEG_W){integ_q[INTEG_W-1]}}, integ_q};
  assign om_hi  = (om_sum > $signed({{(OMEGA_SUM_W - PERIOD_W){1'b0}}, cfg_i.period_max}))
                ? $signed({{(OMEGA_SUM_W - PERIOD_W){1'b0}}, cfg_i.period_max}) : om_sum;
  assign om_lim = (om_hi < $signed({{(OMEGA_SUM_W - PERIOD_W){1'b0}}, cfg_i.period_min}))
                ? $signed({{(OMEGA_SUM_W - PERIOD_W){1'b0}}, cfg_i.period_min}) : om_hi;

  assign emit = (state_q == ST_OMEGA) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      mu_q        <= '0;
      omega_q     <= {{(PHASE_W - PERIOD_W){1'b0}}, PERIOD_NOMINAL_RST};
      integ_q     <= '0;
      prev_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      mu_q        <= mu_d;
      omega_q     <= omega_d;
      integ_q     <= integ_d;
      prev_q      <= prev_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x0_q      <= x0_d;
    sym_q     <= sym_d;
    mid_q     <= mid_d;
    e_q       <= e_d;
    k1_q      <= k1_d;
    out_sym_q <= out_sym_d;
    out_num_q <= out_num_d;
  end

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    mu_d        = mu_q;
    omega_d     = omega_q;
    integ_d     = integ_q;
    prev_d      = prev_q;
    cnt_d       = cnt_q;
    x0_d        = x0_q;
    sym_d       = sym_q;
    mid_d       = mid_q;
    e_d         = e_q;
    k1_d        = k1_q;
    out_sym_d   = out_sym_q;
    out_num_d   = out_num_q;
    out_valid_d = out_valid_q && !out_ready_i;

    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = wp_q;
    mem_req_o.wdata = sample_i;
    mem_req_o.raddr = idx_s0;

    mul_req_o.en = 1'b0;
    mul_req_o.a  = '0;
    mul_req_o.b  = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mem_req_o.we = 1'b1;
          wp_d = wp_q + HIST_AW'(1);
          if (strobe) begin
            mu_d    = mu_diff[PHASE_W-1:0];
            state_d = ST_SYM_RD0;
          end else begin
            mu_d = mu_inc;
          end
        end
      end
      ST_SYM_RD0: begin
        mem_req_o.raddr = idx_s0;
        state_d = ST_SYM_RD1;
      end
      ST_SYM_RD1: begin
        x0_d = mem_rdata_i;
        mem_req_o.raddr = idx_s1;
        state_d = ST_SYM_MUL;
      end
      ST_SYM_MUL: begin
        mul_req_o.en = 1'b1;
        mul_req_o.a  = {{(MUL_A_W - FRAC_W){1'b0}}, mu_q[FRAC_W-1:0]};
        mul_req_o.b  = {{(MUL_B_W - SAMPLE_BITS - 1){rd_diff[SAMPLE_BITS]}}, rd_diff};
        mem_req_o.raddr = idx_m0;
        state_d = ST_SYM_RES;
      end
      ST_SYM_RES: begin
        sym_d = interp_val;
        x0_d  = mem_rdata_i;
        mem_req_o.raddr = idx_m1;
        state_d = ST_MID_MUL;
      end
      ST_MID_MUL: begin
        mul_req_o.en = 1'b1;
        mul_req_o.a  = {{(MUL_A_W - FRAC_W){1'b0}}, frac_mid[FRAC_W-1:0]};
        mul_req_o.b  = {{(MUL_B_W - SAMPLE_BITS - 1){rd_diff[SAMPLE_BITS]}}, rd_diff};
        state_d = ST_MID_RES;
      end
      ST_MID_RES: begin
        mid_d = interp_val;
        state_d = ST_ERR_MUL;
      end
      ST_ERR_MUL: begin
        mul_req_o.en = 1'b1;
        mul_req_o.a  = {{(MUL_A_W - SAMPLE_BITS){mid_q[SAMPLE_BITS-1]}}, mid_q};
        mul_req_o.b  = {{(MUL_B_W - SAMPLE_BITS - 1){err_diff[SAMPLE_BITS]}}, err_diff};
        state_d = ST_K1_MUL;
      end
      ST_K1_MUL: begin
        e_d = prod_i[ERR_W-1:0];
        mul_req_o.en = 1'b1;
        mul_req_o.a  = cfg_i.prop_gain;
        mul_req_o.b  = prod_i[ERR_W-1:0];
        state_d = ST_K2_MUL;
      end
      ST_K2_MUL: begin
        k1_d = k_val;
        mul_req_o.en = 1'b1;
        mul_req_o.a  = cfg_i.integ_gain;
        mul_req_o.b  = e_q;
        state_d = ST_INTEG;
      end
      ST_INTEG: begin
        // saturate the integrator to its signed range
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
          integ_d = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W - 1){1'b0}}}
                                       : {1'b0, {(INTEG_W - 1){1'b1}}};
        end else begin
          integ_d = integ_sum[INTEG_W-1:0];
        end
        state_d = ST_OMEGA;
      end
      ST_OMEGA: begin
        if (emit) begin
          omega_d     = om_lim[PHASE_W-1:0];
          out_valid_d = 1'b1;
          out_sym_d   = sym_q;
          out_num_d   = cnt_q;
          cnt_d       = cnt_q + CNT_W'(1);
          prev_d      = sym_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_i.nominal_ld) begin
      omega_d = {{(PHASE_W - PERIOD_W){1'b0}}, cfg_i.nominal_val};
    end
  end

endmodule

@@ design/gardner_symbol_timing_recovery.sv @@
// top level of the gardner symbol timing recovery block
//
//   channel   dir  fields                        handshake
//   sample_i  in   sample_in                     valid / ready
//   symbol_o  out  symbol_out, symbol_number     valid / ready
//   cfg_i     in   index, data                   valid / ready (always ready)
//
// an item that does not strobe a symbol is taken while the sequencer stays idle; an item
// that strobes holds input ready low until idle again, its steps set by the single history
// read port and the one shared multiplier (two interpolations, error, two gains in turn)
// the finished symbol waits in an output register; a stalled output holds the
// sequencer in its last step only when a second symbol is ready
// reset is asynchronous and active low; the history reads as zero until written
`timescale 1ns / 1ps

module gardner_symbol_timing_recovery (
  input  logic          clk_i,
  input  logic          rst_ni,
  gstr_sample_if.sink   sample_i,
  gstr_symbol_if.source symbol_o,
  gstr_cfg_if.sink      cfg_i
);
  import gstr_pkg::*;

  logic                      in_valid, in_ready, out_valid, out_ready;
  sample_t                   sample_in, symbol_out;
  logic [CNT_W-1:0]          symbol_number;
  cfg_t                      cfg;
  mem_req_t                  mem_req;
  sample_t                   mem_rdata;
  mul_req_t                  mul_req;
  logic signed [MUL_P_W-1:0] prod;

  assign in_valid               = sample_i.valid;
  assign sample_in              = sample_i.sample_in;
  assign sample_i.ready         = in_ready;
  assign out_ready              = symbol_o.ready;
  assign symbol_o.valid         = out_valid;
  assign symbol_o.symbol_out    = symbol_out;
  assign symbol_o.symbol_number = symbol_number;

  gstr_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  gstr_hist_mem u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  gstr_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  gstr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .sample_i    (sample_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .symbol_o    (symbol_out),
    .number_o    (symbol_number),
    .cfg_i       (cfg),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .mul_req_o   (mul_req),
    .prod_i      (prod)
  );

endmodule

@@ design/gstr_checker.sv @@
// port-level checks on the symbol channel, bound to the top level
`timescale 1ns / 1ps

module gstr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input gstr_pkg::sample_t            symbol_out_i,
  input logic [gstr_pkg::CNT_W-1:0]   symbol_number_i
);
  import gstr_pkg::*;

  logic [CNT_W-1:0] expect_num_q;

  // symbols taken so far
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_num_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      expect_num_q <= expect_num_q + CNT_W'(1);
    end
  end

  a_no_out_in_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("symbol valid during reset");

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("symbol valid dropped while stalled");

  a_payload_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(symbol_out_i) && $stable(symbol_number_i))
    else $error("symbol payload changed while stalled");

  a_numbering: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> symbol_number_i == expect_num_q)
    else $error("symbol number out of sequence");

endmodule

bind gardner_symbol_timing_recovery gstr_checker u_gstr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid),
  .out_ready_i     (out_ready),
  .symbol_out_i    (symbol_out),
  .symbol_number_i (symbol_number)
);

@@ verif/tb.sv @@
// self-checking testbench for the gardner symbol timing recovery block
`timescale 1ns / 1ps

module tb;
  import gstr_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE = 24;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 160;
  localparam int HOLD_CYCLES = 400;
  localparam int DIR_ROWS_N = 24;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST = 3'd7;
  localparam logic [PHASE_W-1:0] ONE_SAMPLE = PHASE_W'(65536);
  localparam longint INTEG_HI = 64'sd2147483647;
  localparam longint INTEG_LO = -64'sd2147483648;
  localparam longint GAIN_ROUND = 64'sd1 <<< (GAIN_SHIFT - 1);

  typedef struct packed {
    sample_t          sym;
    logic [CNT_W-1:0] num;
  } symbol_t;

  typedef struct packed {
    sample_t          smp;
    logic             typed;
    sample_t          sym;
    logic [CNT_W-1:0] num;
  } dir_row_t;

  typedef enum logic [1:0] {SET_FIXED, SET_GENTLE, SET_WILD} set_kind_e;

  typedef struct packed {
    set_kind_e kind;
    gain_t     prop;
    gain_t     integ;
    period_t   pmin;
    period_t   pmax;
    period_t   nom;
  } loop_set_t;

  // reset settings: every fourth sample is a symbol, read straight off the newest sample
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{16'sh0000, 1'b0, 16'sh0000, 16'h0000},
    '{16'sh0000, 1'b0, 16'sh0000, 16'h0000},
    '{16'sh0000, 1'b0, 16'sh0000, 16'h0000},
    '{16'sh7FFF, 1'b1, 16'sh7FFF, 16'h0000},
    '{16'shFFFF, 1'b0, 16'sh0000, 16'h0000},
    '{16'sh0001, 1'b0, 16'sh0000, 16'h0000},
    '{16'shFFFF, 1'b0, 16'sh0000, 16'h0000},
    '{16'sh8000, 1'b1, 16'sh8000, 16'h0001},
    '{16'sh5555, 1'b0, 16'sh0000, 16'h0000},
    '{16'shAAAA, 1'b0, 16'sh0000, 16'h0000},
    '{16'sh5555, 1'b0, 16'sh0000, 16'h0000},
    '{16'sh5555, 1'b1, 16'sh5555, 16'h0002},
    '{16'shAAAA, 1'b0, 16'sh0000, 16'h0000},
    '{16'sh5555, 1'b0, 16'sh0000, 16'h0000},
    '{16'shAAAA, 1'b0, 16'sh0000, 16'h0000},
    '{16'shAAAA, 1'b1, 16'shAAAA, 16'h0003},
    '{16'sh7FFF, 1'b0, 16'sh0000, 16'h0000},
    '{16'sh8000, 1'b0, 16'sh0000, 16'h0000},
    '{16'sh0000, 1'b0, 16'sh0000, 16'h0000},
    '{16'sh0001, 1'b0, 16'sh0000, 16'h0000},
    '{16'shFFFF, 1'b0, 16'sh0000, 16'h0000},
    '{16'sh3039, 1'b0, 16'sh0000, 16'h0000},
    '{16'shCFC7, 1'b0, 16'sh0000, 16'h0000},
    '{16'sh0F0F, 1'b0, 16'sh0000, 16'h0000}
  };

  localparam loop_set_t LOOP_SETS [PHASES] = '{
    '{SET_FIXED, 24'h0147AE, 24'h0020C5, 20'h20000, 20'h80000, 20'h40000},
    '{SET_FIXED, 24'h800000, 24'h7FFFFF, 20'h10000, 20'hE0000, 20'hE0000},
    '{SET_FIXED, 24'h7FFFFF, 24'h800000, 20'h10000, 20'hE0000, 20'h10000},
    '{SET_FIXED, 24'h030D40, 24'hFF3CB0, 20'h927C0, 20'h493E0, 20'h6DDD0},
    '{SET_WILD, 24'h0, 24'h0, 20'h0, 20'h0, 20'h0},
    '{SET_FIXED, 24'h000000, 24'h000000, 20'h30000, 20'h50000, 20'h50000},
    '{SET_GENTLE, 24'h0, 24'h0, 20'h0, 20'h0, 20'h0},
    '{SET_WILD, 24'h0, 24'h0, 20'h0, 20'h0, 20'h0}
  };

  logic clk = 1'b0;
  logic rst_n;
  int   cycles = 0;

  gstr_sample_if sample_ch ();
  gstr_symbol_if symbol_ch ();
  gstr_cfg_if    cfg_ch ();

  gardner_symbol_timing_recovery dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .sample_i (sample_ch),
    .symbol_o (symbol_ch),
    .cfg_i    (cfg_ch)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // loop state mirrored from the block
  sample_t            hist [HIST_LEN];
  logic [HIST_AW-1:0] wr_ptr;
  logic [PHASE_W-1:0] mu;
  logic [PHASE_W-1:0] omega;
  logic signed [INTEG_W-1:0] integ;
  sample_t            last_sym;
  logic [CNT_W-1:0]   sym_count;
  gain_t              k_prop;
  gain_t              k_integ;
  period_t            per_min;
  period_t            per_max;
  period_t            per_nom;

  symbol_t symbols_due [$];
  int      errors = 0;
  int      samples_sent = 0;
  int      symbols_checked = 0;
  bit      steady = 1'b0;
  bit      hold_request = 1'b0;
  int      run_left = 0;
  int      level = 0;

  function automatic void loop_reset();
    foreach (hist[i]) hist[i] = '0;
    wr_ptr = '0;
    mu = '0;
    k_prop = '0;
    k_integ = '0;
    per_min = PERIOD_MIN_RST;
    per_max = PERIOD_MAX_RST;
    per_nom = PERIOD_NOMINAL_RST;
    omega = PHASE_W'(per_nom);
    integ = '0;
    last_sym = '0;
    sym_count = '0;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_PROP_GAIN: k_prop = gain_t'(data);
      REG_INTEG_GAIN: k_integ = gain_t'(data);
      REG_PERIOD_MIN: per_min = data[PERIOD_W-1:0];
      REG_PERIOD_MAX: per_max = data[PERIOD_W-1:0];
      REG_PERIOD_NOMINAL: begin
        per_nom = data[PERIOD_W-1:0];
        omega = PHASE_W'(data[PERIOD_W-1:0]);
      end
      default: ;
    endcase
  endfunction

  function automatic longint hist_at(input longint back);
    logic [HIST_AW-1:0] idx;
    idx = HIST_AW'((int'(wr_ptr) + 2 * HIST_LEN - 1 - int'(back % HIST_LEN)) % HIST_LEN);
    return longint'(hist[idx]);
  endfunction

  function automatic longint lerp_at(input longint frac);
    longint n, f, x0, x1;
    n = frac >>> FRAC_W;
    f = frac & 64'sd65535;
    x0 = hist_at(n);
    x1 = hist_at(n + 1);
    return x0 + ((f * (x1 - x0) + 64'sd32768) >>> FRAC_W);
  endfunction

  // one sample into the loop; returns 1 when it strobes a symbol
  function automatic bit timing_loop_step(input sample_t x, output symbol_t res);
    longint s, m, e, k1, k2, v, om;
    res = '0;
    hist[wr_ptr] = x;
    wr_ptr = wr_ptr + 1'b1;
    mu = mu + ONE_SAMPLE;
    if (mu < omega) return 1'b0;
    mu = mu - omega;
    s = lerp_at(longint'(mu));
    m = lerp_at(longint'(mu) + longint'(omega >> 1));
    e = m * (s - longint'(last_sym));
    k1 = (longint'(k_prop) * e + GAIN_ROUND) >>> GAIN_SHIFT;
    k2 = (longint'(k_integ) * e + GAIN_ROUND) >>> GAIN_SHIFT;
    v = longint'(integ) + k2;
    if (v > INTEG_HI) v = INTEG_HI;
    if (v < INTEG_LO) v = INTEG_LO;
    integ = v[INTEG_W-1:0];
    om = longint'(omega) + k1 + v;
    if (om > longint'(per_max)) om = longint'(per_max);
    if (om < longint'(per_min)) om = longint'(per_min);
    omega = om[PHASE_W-1:0];
    res.sym = sample_t'(s);
    res.num = sym_count;
    sym_count = sym_count + 1'b1;
    last_sym = sample_t'(s);
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // mostly held symbol levels with noise, some raw noise and some full-scale or near-zero values
  function automatic sample_t make_sample();
    int r, v, amp;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      if (run_left == 0) begin
        run_left = $urandom_range(1, 14);
        amp = $urandom_range(0, 32767);
        level = ($urandom_range(0, 1) != 0) ? amp : -amp;
      end
      run_left--;
      v = level + int'($urandom_range(0, 1023)) - 512;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return sample_t'(v);
    end
    if (r < 90) return sample_t'($urandom());
    case ($urandom_range(0, 3))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'shFFFF;
    endcase
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
                           input bit last);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_register(idx, data);
    if (last) cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_sample(input sample_t x, input bit typed, input symbol_t typed_sym);
    bit hit;
    symbol_t res;
    int gap;
    sample_ch.valid <= 1'b1;
    sample_ch.sample_in <= x;
    do @(posedge clk); while (!sample_ch.ready);
    samples_sent++;
    hit = timing_loop_step(x, res);
    if (typed) symbols_due.push_back(typed_sym);
    else if (hit) symbols_due.push_back(res);
    gap = pick_gap();
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (symbols_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic check_symbol(input sample_t sym, input logic [CNT_W-1:0] num);
    symbol_t want;
    symbols_checked++;
    if (symbols_due.size() == 0) begin
      errors++;
      $display("%0t: expected no symbol, got symbol %0d number %0d", $time, sym, num);
    end else begin
      want = symbols_due.pop_front();
      if (sym !== want.sym) begin
        errors++;
        $display("%0t: symbol_out expected %0d got %0d", $time, want.sym, sym);
      end
      if (num !== want.num) begin
        errors++;
        $display("%0t: symbol_number expected %0d got %0d", $time, want.num, num);
      end
    end
  endtask

  // symbol receiver with random stalls and one long hold
  initial begin
    int stall_left;
    int hold_left;
    bit hold_done;
    stall_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    symbol_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (symbol_ch.valid && symbol_ch.ready)
        check_symbol(symbol_ch.symbol_out, symbol_ch.symbol_number);
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        symbol_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        symbol_ch.ready <= 1'b0;
      end else begin
        symbol_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d symbols still pending", cycles, symbols_due.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    loop_set_t cfg;
    int g;
    loop_reset();
    rst_n <= 1'b0;
    sample_ch.valid <= 1'b0;
    sample_ch.sample_in <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS_N; i++) begin
      send_sample(DIR_ROWS[i].smp, DIR_ROWS[i].typed, '{DIR_ROWS[i].sym, DIR_ROWS[i].num});
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      cfg = LOOP_SETS[p];
      if (cfg.kind == SET_GENTLE) begin
        g = int'($urandom_range(0, 262144)) - 131072;
        cfg.prop = gain_t'(g);
        g = int'($urandom_range(0, 32768)) - 16384;
        cfg.integ = gain_t'(g);
        cfg.pmin = period_t'($urandom_range(65536, 400000));
        cfg.pmax = period_t'($urandom_range(int'(cfg.pmin), 917504));
        cfg.nom = period_t'($urandom_range(int'(cfg.pmin), int'(cfg.pmax)));
      end else if (cfg.kind == SET_WILD) begin
        cfg.prop = gain_t'($urandom());
        cfg.integ = gain_t'($urandom());
        cfg.pmin = period_t'($urandom_range(65536, 917504));
        cfg.pmax = period_t'($urandom_range(65536, 917504));
        cfg.nom = period_t'($urandom_range(65536, 917504));
        cfg_write(REG_SPARE_FIRST, CFG_DATA_W'($urandom()), 1'b0);
        cfg_write(REG_SPARE_LAST, CFG_DATA_W'($urandom()), 1'b0);
      end
      cfg_write(REG_PERIOD_MIN, CFG_DATA_W'(cfg.pmin), 1'b0);
      cfg_write(REG_PERIOD_MAX, CFG_DATA_W'(cfg.pmax), 1'b0);
      cfg_write(REG_PROP_GAIN, CFG_DATA_W'(cfg.prop), 1'b0);
      cfg_write(REG_INTEG_GAIN, CFG_DATA_W'(cfg.integ), 1'b0);
      cfg_write(REG_PERIOD_NOMINAL, CFG_DATA_W'(cfg.nom), 1'b1);
      steady = (p % 3 == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 0 && i == 80) hold_request = 1'b1;
        send_sample(make_sample(), 1'b0, '0);
      end
    end

    drain();
    $display("%0d samples fed, %0d symbols checked over %0d loop settings", samples_sent,
             symbols_checked, PHASES + 1);
    $display("settings included gain extremes, inverted clamp bounds and spare register writes");
    if (errors == 0 && symbols_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
